// ===== sv/grsb_pkg.sv =====
// ----------------------------------------------------------------------------
// grsb_pkg: shared types for the group reverse stream buffer
// Item types for the input and result channels and the fixed field widths.
// ----------------------------------------------------------------------------
package grsb_pkg;

    localparam int VALUE_W      = 32;
    localparam int GROUP_SIZE_W = 7;

    localparam logic [GROUP_SIZE_W-1:0] GROUP_SIZE_RESET = 7'd2;

    typedef struct packed {
        logic signed [VALUE_W-1:0] item_value;
        logic                      list_end;
    } in_item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] out_value;
        logic                      run_last;
        logic                      out_list_end;
    } out_item_t;

endpackage

// ===== sv/grsb_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// grsb_cmd_queue: two-entry command queue
// Holds group drain commands between the front and the back.
// ----------------------------------------------------------------------------
module grsb_cmd_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic             head_valid,
    output logic [WIDTH-1:0] head_data,
    output logic             full
);

    logic [WIDTH-1:0] entry_reg [2];
    logic             wptr_reg;
    logic             wptr_next;
    logic             rptr_reg;
    logic             rptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;

    assign head_valid = (count_reg != 2'd0);
    assign full       = (count_reg == 2'd2);
    assign head_data  = entry_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wptr_next = ~wptr_reg;
        end
        if (pop)
        begin
            rptr_next = ~rptr_reg;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("command queue pushed while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("command queue popped while empty");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 2'd1))
        else $error("command queue count did not advance on push");

endmodule

// ===== sv/grsb_front.sv =====
// ----------------------------------------------------------------------------
// grsb_front: item intake and group classification
// Writes each item into the open bank, decides when a group is complete or
// the list ends, and queues a drain command for the back.
// ----------------------------------------------------------------------------
module grsb_front import grsb_pkg::*; #(
    parameter int MAX_GROUP = 64,
    localparam int CNT_W    = $clog2(MAX_GROUP + 1),
    localparam int IDX_W    = $clog2(MAX_GROUP),
    localparam int ADDR_W   = IDX_W + 1,
    localparam int CMD_W    = CNT_W + 3,
    localparam int WR_W     = ADDR_W + 1 + VALUE_W
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [GROUP_SIZE_W-1:0] cfg_wdata,
    input  logic                    item_valid,
    output logic                    item_stall,
    input  in_item_t                item,
    output logic [WR_W-1:0]         mem_wr,
    output logic                    cmd_push,
    output logic [CMD_W-1:0]        cmd_data,
    input  logic                    cmd_full,
    input  logic                    bank_free,
    input  logic                    free_bank
);

    localparam int CMP_W = (CNT_W > GROUP_SIZE_W) ? CNT_W : GROUP_SIZE_W;

    typedef struct packed {
        logic               bank;
        logic [CNT_W-1:0]   count;
        logic               reverse;
        logic               list_end;
    } cmd_t;

    typedef struct packed {
        logic               en;
        logic [ADDR_W-1:0]  addr;
        logic [VALUE_W-1:0] value;
    } wr_t;

    logic [GROUP_SIZE_W-1:0] group_size_reg;
    logic [IDX_W-1:0]        fill_reg;
    logic [IDX_W-1:0]        fill_next;
    logic                    bank_reg;
    logic                    bank_next;
    logic [1:0]              busy_reg;
    logic [1:0]              busy_next;
    logic [CMP_W-1:0]        size_ext;
    logic [CNT_W-1:0]        eff_size;
    logic [CNT_W-1:0]        new_count;
    logic                    accept;
    logic                    full_group;
    logic                    flush;
    cmd_t                    cmd;
    wr_t                     wr;

    // A size above the store depth acts as the depth; zero acts as one.
    always_comb
    begin
        size_ext = CMP_W'(group_size_reg);
        if (size_ext > CMP_W'(MAX_GROUP))
        begin
            eff_size = CNT_W'(MAX_GROUP);
        end
        else if (size_ext == '0)
        begin
            eff_size = CNT_W'(1);
        end
        else
        begin
            eff_size = CNT_W'(size_ext);
        end
    end

    assign item_stall = busy_reg[bank_reg];
    assign accept     = item_valid && !item_stall;
    assign new_count  = CNT_W'(fill_reg) + CNT_W'(1);
    assign full_group = (new_count >= eff_size);
    assign flush      = full_group || item.list_end;

    always_comb
    begin
        wr.en    = accept;
        wr.addr  = {bank_reg, fill_reg};
        wr.value = item.item_value;
        mem_wr   = wr;

        cmd.bank     = bank_reg;
        cmd.count    = new_count;
        cmd.reverse  = full_group;
        cmd.list_end = item.list_end;
        cmd_data     = cmd;
        cmd_push     = accept && flush;

        fill_next = fill_reg;
        bank_next = bank_reg;
        busy_next = busy_reg;
        if (bank_free)
        begin
            busy_next[free_bank] = 1'b0;
        end
        if (accept)
        begin
            if (flush)
            begin
                fill_next           = '0;
                bank_next           = ~bank_reg;
                busy_next[bank_reg] = 1'b1;
            end
            else
            begin
                fill_next = IDX_W'(new_count);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_size_reg <= GROUP_SIZE_RESET;
            fill_reg       <= '0;
            bank_reg       <= 1'b0;
            busy_reg       <= 2'b00;
        end
        else
        begin
            if (cfg_we)
            begin
                group_size_reg <= cfg_wdata;
            end
            fill_reg <= fill_next;
            bank_reg <= bank_next;
            busy_reg <= busy_next;
        end
    end

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_push |-> !cmd_full)
        else $error("drain command issued with the queue full");

    a_free_was_busy: assert property (@(posedge clk) disable iff (!rst_n)
        bank_free |-> busy_reg[free_bank])
        else $error("bank released that was not held");

    a_fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        CNT_W'(fill_reg) < CNT_W'(MAX_GROUP))
        else $error("fill count reached the store depth");

endmodule

// ===== sv/grsb_back.sv =====
// ----------------------------------------------------------------------------
// grsb_back: group store and drain sequencer
// Holds both banks, walks each queued group forward or reversed through the
// registered read port, and buffers results ahead of the output stall.
// ----------------------------------------------------------------------------
module grsb_back import grsb_pkg::*; #(
    parameter int MAX_GROUP = 64,
    localparam int CNT_W    = $clog2(MAX_GROUP + 1),
    localparam int IDX_W    = $clog2(MAX_GROUP),
    localparam int ADDR_W   = IDX_W + 1,
    localparam int CMD_W    = CNT_W + 3,
    localparam int WR_W     = ADDR_W + 1 + VALUE_W
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [WR_W-1:0]  mem_wr,
    input  logic             cmd_valid,
    input  logic [CMD_W-1:0] cmd_data,
    output logic             cmd_pop,
    output logic             bank_free,
    output logic             free_bank,
    output logic             result_valid,
    input  logic             result_stall,
    output out_item_t        result
);

    typedef struct packed {
        logic               bank;
        logic [CNT_W-1:0]   count;
        logic               reverse;
        logic               list_end;
    } cmd_t;

    typedef struct packed {
        logic               en;
        logic [ADDR_W-1:0]  addr;
        logic [VALUE_W-1:0] value;
    } wr_t;

    localparam int MEM_DEPTH = 1 << ADDR_W;

    logic [VALUE_W-1:0] mem [MEM_DEPTH];

    wr_t                wr;
    cmd_t               cmd_in;
    cmd_t               cmd_reg;
    logic               active_reg;
    logic [IDX_W-1:0]   pos_reg;
    logic [CNT_W-1:0]   last_pos;
    logic [IDX_W-1:0]   rd_idx;
    logic [ADDR_W-1:0]  rd_addr;
    logic               room;
    logic               issue;
    logic               last_issue;

    logic [VALUE_W-1:0] rd_value_reg;
    logic               rd_valid_reg;
    logic               rd_last_reg;
    logic               rd_end_reg;

    out_item_t          obuf_reg [3];
    logic [1:0]         owptr_reg;
    logic [1:0]         orptr_reg;
    logic [1:0]         ocount_reg;
    logic [1:0]         ocount_next;
    logic               opop;
    out_item_t          rd_item;

    assign wr     = mem_wr;
    assign cmd_in = cmd_data;

    // One result may still be in the read register, so leave room for it.
    assign room       = ({1'b0, ocount_reg} + {2'b00, rd_valid_reg}) < 3'd3;
    assign issue      = active_reg && room;
    assign last_pos   = cmd_reg.count - CNT_W'(1);
    assign last_issue = issue && (CNT_W'(pos_reg) == last_pos);
    assign rd_idx     = cmd_reg.reverse ? IDX_W'(last_pos - CNT_W'(pos_reg)) : pos_reg;
    assign rd_addr    = {cmd_reg.bank, rd_idx};
    assign cmd_pop    = cmd_valid && (!active_reg || last_issue);
    assign bank_free  = last_issue;
    assign free_bank  = cmd_reg.bank;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.value;
        end
        if (issue)
        begin
            rd_value_reg <= mem[rd_addr];
            rd_last_reg  <= last_issue;
            rd_end_reg   <= last_issue && cmd_reg.list_end;
        end
        if (cmd_pop)
        begin
            cmd_reg <= cmd_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= 1'b0;
            pos_reg      <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= issue;
            if (cmd_pop)
            begin
                active_reg <= 1'b1;
                pos_reg    <= '0;
            end
            else if (last_issue)
            begin
                active_reg <= 1'b0;
            end
            else if (issue)
            begin
                pos_reg <= pos_reg + IDX_W'(1);
            end
        end
    end

    // Three-entry result buffer ahead of the output handshake.
    assign result_valid = (ocount_reg != 2'd0);
    assign result       = obuf_reg[orptr_reg];
    assign opop         = result_valid && !result_stall;

    always_comb
    begin
        rd_item.out_value    = rd_value_reg;
        rd_item.run_last     = rd_last_reg;
        rd_item.out_list_end = rd_end_reg;
        ocount_next          = ocount_reg;
        if (rd_valid_reg && !opop)
        begin
            ocount_next = ocount_reg + 2'd1;
        end
        else if (opop && !rd_valid_reg)
        begin
            ocount_next = ocount_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_valid_reg)
        begin
            obuf_reg[owptr_reg] <= rd_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owptr_reg  <= 2'd0;
            orptr_reg  <= 2'd0;
            ocount_reg <= 2'd0;
        end
        else
        begin
            ocount_reg <= ocount_next;
            if (rd_valid_reg)
            begin
                owptr_reg <= (owptr_reg == 2'd2) ? 2'd0 : owptr_reg + 2'd1;
            end
            if (opop)
            begin
                orptr_reg <= (orptr_reg == 2'd2) ? 2'd0 : orptr_reg + 2'd1;
            end
        end
    end

    a_buffer_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> (ocount_reg != 2'd3 || opop))
        else $error("result buffer overflow");

    a_issue_only_active: assert property (@(posedge clk) disable iff (!rst_n)
        issue |-> (CNT_W'(pos_reg) < cmd_reg.count))
        else $error("read issued beyond the group");

    a_read_follows_issue: assert property (@(posedge clk) disable iff (!rst_n)
        issue |=> rd_valid_reg)
        else $error("read data missing after issue");

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ocount_reg != 2'd3 || !rd_valid_reg || opop)
        else $error("result buffer count out of range");

endmodule

// ===== sv/group_reverse_stream_buffer.sv =====
// ----------------------------------------------------------------------------
// group_reverse_stream_buffer: reverses a value stream in groups
// Buffers items until a group of the configured size fills, then emits the
// group reversed; a list that ends early emits its partial group in order.
//
//   channel   handshake            payload      direction
//   item      item_valid/stall     in_item_t    in
//   result    result_valid/stall   out_item_t   out
//   config    cfg_we               cfg_wdata    in
//
// The front takes one item per cycle, unless stalled, into one of two banks
// while the other bank drains, one result per cycle while the output does not
// stall, through the single registered read port. Drain commands pass the
// command queue and command register, results the read register and result
// buffer; items stall only while both banks still hold undrained groups.
// Reset clears control state only; the banks need no clearing pass.
// ----------------------------------------------------------------------------
module group_reverse_stream_buffer import grsb_pkg::*; #(
    parameter int MAX_GROUP = 64
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [GROUP_SIZE_W-1:0] cfg_wdata,
    input  logic                    item_valid,
    output logic                    item_stall,
    input  in_item_t                item,
    output logic                    result_valid,
    input  logic                    result_stall,
    output out_item_t               result
);

    localparam int CNT_W  = $clog2(MAX_GROUP + 1);
    localparam int IDX_W  = $clog2(MAX_GROUP);
    localparam int ADDR_W = IDX_W + 1;
    localparam int CMD_W  = CNT_W + 3;
    localparam int WR_W   = ADDR_W + 1 + VALUE_W;

    logic [WR_W-1:0]  mem_wr;
    logic             cmd_push;
    logic [CMD_W-1:0] cmd_wdata;
    logic             cmd_full;
    logic             cmd_valid;
    logic [CMD_W-1:0] cmd_rdata;
    logic             cmd_pop;
    logic             bank_free;
    logic             free_bank;

    grsb_front #(
        .MAX_GROUP (MAX_GROUP)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .mem_wr     (mem_wr),
        .cmd_push   (cmd_push),
        .cmd_data   (cmd_wdata),
        .cmd_full   (cmd_full),
        .bank_free  (bank_free),
        .free_bank  (free_bank)
    );

    grsb_cmd_queue #(
        .WIDTH (CMD_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (cmd_push),
        .push_data  (cmd_wdata),
        .pop        (cmd_pop),
        .head_valid (cmd_valid),
        .head_data  (cmd_rdata),
        .full       (cmd_full)
    );

    grsb_back #(
        .MAX_GROUP (MAX_GROUP)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .mem_wr       (mem_wr),
        .cmd_valid    (cmd_valid),
        .cmd_data     (cmd_rdata),
        .cmd_pop      (cmd_pop),
        .bank_free    (bank_free),
        .free_bank    (free_bank),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
